// ===== rtl/i2jd_pkg.sv =====
// Shared types and constants for the ISO-2022-JP decoder.
// Used by every module of the block; no dependencies.
package i2jd_pkg;

    localparam int TABLE_DEPTH_DEF = 16384;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int INDEX_W         = 14;
    localparam int RUNE_W          = 16;
    localparam int ERR_W           = 32;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_PAREN    = 8'h28;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_J        = 8'h4A;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_YEN      = 8'hA5;
    localparam logic [7:0] CH_OVERLINE = 8'hAF;
    localparam logic [7:0] CH_PAD      = 8'h21;
    localparam logic [7:0] HIGH_BIT    = 8'h80;

    localparam logic [INDEX_W-1:0] KUTEN_ROW  = 14'd100;
    localparam logic [INDEX_W-1:0] KUTEN_BIAS = 14'd3232;

    localparam logic [RUNE_W-1:0] BAD_RUNE_RST = 16'hFFFD;

    localparam logic CFG_DROP_UNMAPPED = 1'b0;
    localparam logic CFG_BAD_RUNE      = 1'b1;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_LOOK,
        CMD_WRITE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [1:0]               cnt;
        logic [2:0][7:0]          lits;
        logic [INDEX_W-1:0]       addr;
        logic                     hit;
        logic                     wr_mapped;
        logic [RUNE_W-1:0]        wr_rune;
    } t_cmd;

    typedef struct packed {
        logic                     valid;
        logic [RUNE_W-1:0]        rune;
        logic                     unmapped;
        logic [ERR_W-1:0]         err;
        logic                     last;
    } t_res;

endpackage

// ===== rtl/i2jd_front.sv =====
// Front end: escape and pair parser, turns each transaction that loads the table or yields output into a queue command.
// Depends on i2jd_pkg.
module i2jd_front #(
    parameter int TABLE_DEPTH = i2jd_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [7:0]                      i_byte,
    input  logic                            i_eoi,
    input  logic [i2jd_pkg::INDEX_W-1:0]    i_index,
    input  logic                            i_mapped,
    input  logic [i2jd_pkg::RUNE_W-1:0]     i_rune,
    input  logic                            i_q_full,
    output logic                            o_push,
    output i2jd_pkg::t_cmd                  o_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_DOLLAR,
        PH_PAREN,
        PH_PAIR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_two, n_two;
    logic        r_roman, n_roman;
    logic [7:0]  r_fb, n_fb;

    logic [2:0][7:0]                lits;
    logic [1:0]                     pre_n;
    logic [1:0]                     cnt;
    logic                           run_idle;
    logic                           idle_emit;
    logic                           do_look;
    logic [7:0]                     b2;
    logic [i2jd_pkg::INDEX_W-1:0]   ksum;
    logic [i2jd_pkg::INDEX_W-1:0]   kidx;
    logic                           khit;
    logic                           whit;
    logic                           accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase   = r_phase;
        n_two     = r_two;
        n_roman   = r_roman;
        n_fb      = r_fb;
        lits      = '0;
        pre_n     = 2'd0;
        run_idle  = 1'b0;
        idle_emit = 1'b0;
        do_look   = 1'b0;
        b2        = i_byte;
        unique case (r_phase)
            PH_ESC: begin
                if (!i_eoi && i_byte == i2jd_pkg::CH_DOLLAR) begin
                    n_phase = PH_DOLLAR;
                end else if (!i_eoi && i_byte == i2jd_pkg::CH_PAREN) begin
                    n_phase = PH_PAREN;
                end else begin
                    lits[0]  = i2jd_pkg::CH_ESC;
                    pre_n    = 2'd1;
                    run_idle = 1'b1;
                end
            end
            PH_DOLLAR: begin
                if (!i_eoi && (i_byte == i2jd_pkg::CH_AT || i_byte == i2jd_pkg::CH_B)) begin
                    n_two   = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    lits[0]  = i2jd_pkg::CH_ESC;
                    lits[1]  = i2jd_pkg::CH_DOLLAR;
                    pre_n    = 2'd2;
                    run_idle = 1'b1;
                end
            end
            PH_PAREN: begin
                if (!i_eoi && (i_byte == i2jd_pkg::CH_J || i_byte == i2jd_pkg::CH_H
                               || i_byte == i2jd_pkg::CH_B)) begin
                    n_roman = (i_byte == i2jd_pkg::CH_J);
                    n_two   = 1'b0;
                    n_phase = PH_IDLE;
                end else begin
                    lits[0]  = i2jd_pkg::CH_ESC;
                    lits[1]  = i2jd_pkg::CH_PAREN;
                    pre_n    = 2'd2;
                    run_idle = 1'b1;
                end
            end
            PH_PAIR: begin
                n_phase = PH_IDLE;
                if (i_eoi) begin
                    b2      = i2jd_pkg::CH_PAD | (r_fb & i2jd_pkg::HIGH_BIT);
                    do_look = 1'b1;
                end else if (i_byte[7] != r_fb[7]) begin
                    lits[0]  = r_fb;
                    pre_n    = 2'd1;
                    run_idle = 1'b1;
                end else begin
                    do_look = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        if (run_idle) begin
            n_phase = PH_IDLE;
            if (!i_eoi) begin
                if (i_byte == i2jd_pkg::CH_ESC) begin
                    n_phase = PH_ESC;
                end else if (!r_two && !i_byte[7]) begin
                    idle_emit = 1'b1;
                    if (r_roman && i_byte == i2jd_pkg::CH_BSLASH) begin
                        lits[pre_n] = i2jd_pkg::CH_YEN;
                    end else if (r_roman && i_byte == i2jd_pkg::CH_TILDE) begin
                        lits[pre_n] = i2jd_pkg::CH_OVERLINE;
                    end else begin
                        lits[pre_n] = i_byte;
                    end
                end else begin
                    n_fb    = i_byte;
                    n_phase = PH_PAIR;
                end
            end
        end
        cnt = pre_n + {1'b0, idle_emit};
    end

    // kuten index: row * 100 + cell - 3232
    assign ksum = (i2jd_pkg::INDEX_W'(r_fb[6:0]) * i2jd_pkg::KUTEN_ROW)
                + i2jd_pkg::INDEX_W'(b2[6:0]);
    assign kidx = ksum - i2jd_pkg::KUTEN_BIAS;
    assign khit = (ksum >= i2jd_pkg::KUTEN_BIAS) && (32'(kidx) < 32'(TABLE_DEPTH));
    assign whit = 32'(i_index) < 32'(TABLE_DEPTH);

    always_comb begin
        o_cmd           = '0;
        o_cmd.lits      = lits;
        o_cmd.cnt       = cnt;
        o_cmd.wr_mapped = i_mapped;
        o_cmd.wr_rune   = i_rune;
        if (i_op) begin
            o_cmd.kind = i2jd_pkg::CMD_WRITE;
            o_cmd.addr = i_index;
            o_cmd.hit  = whit;
        end else if (do_look) begin
            o_cmd.kind = i2jd_pkg::CMD_LOOK;
            o_cmd.addr = kidx;
            o_cmd.hit  = khit;
        end else begin
            o_cmd.kind = i2jd_pkg::CMD_LIT;
        end
    end

    assign o_push = accept && (i_op || do_look || cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_two   <= 1'b0;
            r_roman <= 1'b0;
            r_fb    <= '0;
        end else if (accept && !i_op) begin
            r_phase <= n_phase;
            r_two   <= n_two;
            r_roman <= n_roman;
            r_fb    <= n_fb;
        end
    end

endmodule

// ===== rtl/i2jd_queue.sv =====
// Command queue between parser and back end.
// Depends on i2jd_pkg for the command type.
module i2jd_queue #(
    parameter int DEPTH = i2jd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2jd_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output i2jd_pkg::t_cmd  o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2jd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/i2jd_back.sv =====
// Back end: kuten table, lookup, error counter and result sequencer.
// Depends on i2jd_pkg.
module i2jd_back #(
    parameter int TABLE_DEPTH = i2jd_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  i2jd_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    input  logic                         i_drop,
    input  logic [i2jd_pkg::RUNE_W-1:0]  i_bad_rune,
    input  logic                         i_out_ready,
    output i2jd_pkg::t_res               o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int MW = i2jd_pkg::RUNE_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } t_state;

    logic [MW-1:0] r_mem [TABLE_DEPTH];
    logic [MW-1:0] r_rd;

    t_state                               r_state, n_state;
    logic [2:0][i2jd_pkg::RUNE_W-1:0]     r_buf, n_buf;
    logic                                 r_bad, n_bad;
    logic [1:0]                           r_cnt, n_cnt;
    logic [1:0]                           r_idx, n_idx;
    logic                                 r_hit, n_hit;
    logic [i2jd_pkg::ERR_W-1:0]           r_err, n_err;
    i2jd_pkg::t_res                       r_out, n_out;

    logic out_free;
    logic emit_done;
    logic mem_we;
    logic mem_re;

    assign out_free  = !r_out.valid || i_out_ready;
    assign emit_done = (r_state == S_EMIT) && out_free && (r_idx == r_cnt - 2'd1);
    assign o_pop     = i_q_valid && ((r_state == S_IDLE) || emit_done);
    assign mem_we    = o_pop && (i_cmd.kind == i2jd_pkg::CMD_WRITE) && i_cmd.hit;
    assign mem_re    = o_pop && (i_cmd.kind == i2jd_pkg::CMD_LOOK) && i_cmd.hit;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.addr[AW-1:0]] <= {i_cmd.wr_mapped, i_cmd.wr_rune};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= r_mem[i_cmd.addr[AW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_bad   = r_bad;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_hit   = r_hit;
        n_err   = r_err;
        n_out   = r_out;
        if (r_out.valid && i_out_ready) begin
            n_out.valid = 1'b0;
        end
        unique case (r_state)
            S_LOOK: begin
                n_cnt = 2'd1;
                n_idx = 2'd0;
                if (r_hit && r_rd[MW-1]) begin
                    n_buf[0] = r_rd[i2jd_pkg::RUNE_W-1:0];
                    n_bad    = 1'b0;
                    n_state  = S_EMIT;
                end else begin
                    n_err = (r_err == '1) ? r_err : r_err + 1'b1;
                    n_buf[0] = i_bad_rune;
                    n_bad    = 1'b1;
                    n_state  = i_drop ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out.valid    = 1'b1;
                    n_out.rune     = r_buf[r_idx];
                    n_out.unmapped = r_bad;
                    n_out.err      = r_err;
                    n_out.last     = (r_idx == r_cnt - 2'd1);
                    n_idx          = r_idx + 2'd1;
                    if (r_idx == r_cnt - 2'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_pop) begin
            case (i_cmd.kind)
                i2jd_pkg::CMD_LIT: begin
                    n_buf[0] = i2jd_pkg::RUNE_W'(i_cmd.lits[0]);
                    n_buf[1] = i2jd_pkg::RUNE_W'(i_cmd.lits[1]);
                    n_buf[2] = i2jd_pkg::RUNE_W'(i_cmd.lits[2]);
                    n_bad    = 1'b0;
                    n_cnt    = i_cmd.cnt;
                    n_idx    = 2'd0;
                    n_state  = S_EMIT;
                end
                i2jd_pkg::CMD_LOOK: begin
                    n_hit   = i_cmd.hit;
                    n_state = S_LOOK;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= '0;
            r_out.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_out.valid <= n_out.valid;
        end
        r_buf          <= n_buf;
        r_bad          <= n_bad;
        r_cnt          <= n_cnt;
        r_idx          <= n_idx;
        r_hit          <= n_hit;
        r_out.rune     <= n_out.rune;
        r_out.unmapped <= n_out.unmapped;
        r_out.err      <= n_out.err;
        r_out.last     <= n_out.last;
    end

endmodule

// ===== rtl/iso2022jp_decoder_top.sv =====
// ISO-2022-JP decoder top level: stream ports, configuration registers, module wiring.
// Depends on i2jd_pkg, i2jd_front, i2jd_queue, i2jd_back.
//
// Decodes an ISO-2022-JP byte stream into 16-bit runes; a transaction with tuser set loads
// one kuten table entry instead. The front parser takes one input transaction per cycle
// while its command queue has room; escape bytes and the first byte of a pair only update
// the parser. The back end picks up the next command in the cycle that sends the last rune
// of the current one, so commands follow back to back; a broken escape replay sends up to three
// runes, a kuten lookup passes through the S_LOOK state because the table read is registered,
// and a dropped lookup goes from S_LOOK back to idle. From idle a plain byte passes through the
// command queue, the S_EMIT state and the output register, a lookup also through S_LOOK.
// Output stalls hold the back end. Table entries are undefined until loaded; no clearing
// pass is run after reset.
module iso2022jp_decoder_top #(
    parameter int TABLE_DEPTH = i2jd_pkg::TABLE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = i2jd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,   // byte_in, entry_index, entry_mapped, entry_rune, pad
    input  logic         i_s_axis_tuser,   // op
    input  logic         i_s_axis_tlast,   // end_of_input
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [55:0]  o_m_axis_tdata,   // rune, unmapped, error_total, pad
    output logic         o_m_axis_tlast,   // last
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic                          r_drop;
    logic [i2jd_pkg::RUNE_W-1:0]   r_bad_rune;

    logic            q_full;
    logic            q_valid;
    logic            push;
    logic            pop;
    i2jd_pkg::t_cmd  cmd_in;
    i2jd_pkg::t_cmd  cmd_out;
    i2jd_pkg::t_res  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop     <= 1'b0;
            r_bad_rune <= i2jd_pkg::BAD_RUNE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                i2jd_pkg::CFG_DROP_UNMAPPED: r_drop     <= i_cfg_data[0];
                i2jd_pkg::CFG_BAD_RUNE:      r_bad_rune <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2jd_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_op     (i_s_axis_tuser),
        .i_byte   (i_s_axis_tdata[7:0]),
        .i_eoi    (i_s_axis_tlast),
        .i_index  (i_s_axis_tdata[21:8]),
        .i_mapped (i_s_axis_tdata[22]),
        .i_rune   (i_s_axis_tdata[38:23]),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    i2jd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (cmd_out)
    );

    i2jd_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .i_drop      (r_drop),
        .i_bad_rune  (r_bad_rune),
        .i_out_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tvalid = res.valid;
    assign o_m_axis_tlast  = res.last;
    assign o_m_axis_tdata  = {7'b0, res.err, res.unmapped, res.rune};

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for iso2022jp_decoder_top: directed table, then random byte streams.
// Predicts runes, error totals and last flags from its own decoder state and kuten table copy.
// Depends on i2jd_pkg and the decoder RTL only.
module tb;

    localparam int KUTEN_DEPTH  = i2jd_pkg::TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 460;

    typedef enum logic [2:0] {ST_IDLE, ST_ESC, ST_DOLLAR, ST_PAREN, ST_PAIR} t_dec_phase;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} t_exp_kind;

    typedef struct packed {
        logic        load;
        logic [7:0]  octet;
        logic        eoi;
        logic [13:0] kidx;
        logic        mapped;
        logic [15:0] rune;
    } t_jis_item;

    typedef struct packed {
        logic [15:0] rune;
        logic        unmapped;
        logic [31:0] err;
        logic        last;
    } t_rune_res;

    typedef struct packed {
        t_exp_kind kind;
        t_jis_item stim;
        t_rune_res want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;   // byte_in, entry_index, entry_mapped, entry_rune, pad
    logic        i_s_axis_tuser  = 1'b0; // op
    logic        i_s_axis_tlast  = 1'b0; // end_of_input
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;         // rune, unmapped, error_total, pad
    logic        o_m_axis_tlast;         // last
    logic        i_cfg_wr_en     = 1'b0;
    logic        i_cfg_index     = 1'b0;
    logic [15:0] i_cfg_data      = '0;

    iso2022jp_decoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // decoder state mirror
    t_dec_phase  dec_phase   = ST_IDLE;
    bit          wide_mode   = 0;
    bit          roman_on    = 0;
    logic [7:0]  first_octet = '0;
    logic [31:0] err_count   = '0;
    bit          drop_cfg    = 0;
    logic [15:0] bad_cfg     = i2jd_pkg::BAD_RUNE_RST;
    bit          tbl_mapped  [KUTEN_DEPTH];
    logic [15:0] tbl_rune    [KUTEN_DEPTH];
    bit          tbl_written [KUTEN_DEPTH];

    t_rune_res   stage [3];
    int          stage_n;
    t_rune_res   expected_runes [$];
    t_dir_row    dir_rows [$];
    t_rune_res   no_res = '0;
    int          fed_count  = 0;
    int          fail_count = 0;
    bit          tx_burst   = 0;
    bit          rx_free    = 0;
    int          rx_stall   = 0;
    int          rx_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int kuten_index(logic [7:0] hi, logic [7:0] lo);
        return int'(hi[6:0]) * int'(i2jd_pkg::KUTEN_ROW) + int'(lo[6:0])
               - int'(i2jd_pkg::KUTEN_BIAS);
    endfunction

    // table index this transaction will read, or -1
    function automatic int lookup_target(t_jis_item it);
        logic [7:0] c;
        int n;
        lookup_target = -1;
        if (!it.load && dec_phase == ST_PAIR) begin
            c = it.eoi ? (i2jd_pkg::CH_PAD | (first_octet & i2jd_pkg::HIGH_BIT)) : it.octet;
            n = kuten_index(first_octet, c);
            if (c[7] == first_octet[7] && n >= 0 && n < KUTEN_DEPTH)
                lookup_target = n;
        end
    endfunction

    task automatic emit(logic [15:0] r, bit bad);
        if (stage_n < 3) begin
            stage[stage_n].rune     = r;
            stage[stage_n].unmapped = bad;
            stage_n++;
        end
    endtask

    task automatic kuten_lookup(logic [7:0] hi, logic [7:0] lo);
        int n;
        n = kuten_index(hi, lo);
        if (n >= 0 && n < KUTEN_DEPTH && tbl_mapped[n]) begin
            emit(tbl_rune[n], 1'b0);
        end else begin
            if (err_count != 32'hFFFF_FFFF)
                err_count++;
            if (!drop_cfg)
                emit(bad_cfg, 1'b1);
        end
    endtask

    task automatic decode_step(t_jis_item it);
        int c;
        bit done;
        stage_n = 0;
        if (it.load) begin
            tbl_mapped[it.kidx]  = it.mapped;
            tbl_rune[it.kidx]    = it.rune;
            tbl_written[it.kidx] = 1;
            return;
        end
        c = it.eoi ? -1 : int'(it.octet);
        done = 0;
        while (!done) begin
            done = 1;
            case (dec_phase)
                ST_ESC: begin
                    if (c == int'(i2jd_pkg::CH_DOLLAR)) begin
                        dec_phase = ST_DOLLAR;
                    end else if (c == int'(i2jd_pkg::CH_PAREN)) begin
                        dec_phase = ST_PAREN;
                    end else begin
                        emit({8'h00, i2jd_pkg::CH_ESC}, 1'b0);
                        dec_phase = ST_IDLE;
                        done = 0;
                    end
                end
                ST_DOLLAR: begin
                    dec_phase = ST_IDLE;
                    if (c == int'(i2jd_pkg::CH_AT) || c == int'(i2jd_pkg::CH_B)) begin
                        wide_mode = 1;
                    end else begin
                        emit({8'h00, i2jd_pkg::CH_ESC}, 1'b0);
                        emit({8'h00, i2jd_pkg::CH_DOLLAR}, 1'b0);
                        done = 0;
                    end
                end
                ST_PAREN: begin
                    dec_phase = ST_IDLE;
                    if (c == int'(i2jd_pkg::CH_J) || c == int'(i2jd_pkg::CH_H)
                        || c == int'(i2jd_pkg::CH_B)) begin
                        roman_on  = (c == int'(i2jd_pkg::CH_J));
                        wide_mode = 0;
                    end else begin
                        emit({8'h00, i2jd_pkg::CH_ESC}, 1'b0);
                        emit({8'h00, i2jd_pkg::CH_PAREN}, 1'b0);
                        done = 0;
                    end
                end
                ST_PAIR: begin
                    if (c < 0)
                        c = int'(i2jd_pkg::CH_PAD | (first_octet & i2jd_pkg::HIGH_BIT));
                    dec_phase = ST_IDLE;
                    if (c[7] != first_octet[7]) begin
                        emit({8'h00, first_octet}, 1'b0);
                        done = 0;
                    end else begin
                        kuten_lookup(first_octet, c[7:0]);
                    end
                end
                default: begin
                    dec_phase = ST_IDLE;
                    if (c == int'(i2jd_pkg::CH_ESC)) begin
                        dec_phase = ST_ESC;
                    end else if (c >= 0) begin
                        if (!wide_mode && c < 128) begin
                            if (roman_on && c == int'(i2jd_pkg::CH_BSLASH))
                                emit({8'h00, i2jd_pkg::CH_YEN}, 1'b0);
                            else if (roman_on && c == int'(i2jd_pkg::CH_TILDE))
                                emit({8'h00, i2jd_pkg::CH_OVERLINE}, 1'b0);
                            else
                                emit({8'h00, c[7:0]}, 1'b0);
                        end else begin
                            first_octet = c[7:0];
                            dec_phase   = ST_PAIR;
                        end
                    end
                end
            endcase
        end
        for (int k = 0; k < stage_n; k++) begin
            stage[k].err  = err_count;
            stage[k].last = (k == stage_n - 1);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic drive_item(t_jis_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.load;
        i_s_axis_tlast  <= it.eoi;
        i_s_axis_tdata  <= {1'b0, it.rune, it.mapped, it.kidx, it.octet};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // loads an entry first when a pair would read an unwritten one
    task automatic feed(t_jis_item it, t_exp_kind kind, t_rune_res typed);
        t_jis_item ld;
        int n;
        n = lookup_target(it);
        if (n >= 0 && !tbl_written[n]) begin
            ld.load   = 1'b1;
            ld.octet  = 8'($urandom);
            ld.eoi    = 1'($urandom);
            ld.kidx   = 14'(n);
            ld.mapped = ($urandom_range(0, 4) != 0);
            ld.rune   = 16'($urandom);
            drive_item(ld);
            decode_step(ld);
            fed_count++;
        end
        drive_item(it);
        decode_step(it);
        fed_count++;
        if (kind == EXP_MODEL) begin
            for (int k = 0; k < stage_n; k++)
                expected_runes.push_back(stage[k]);
        end else if (kind == EXP_ONE) begin
            expected_runes.push_back(typed);
        end
    endtask

    task automatic feed_byte(int c);
        t_jis_item it;
        it.load   = 1'b0;
        it.eoi    = (c < 0);
        it.octet  = (c < 0) ? 8'($urandom) : 8'(c);
        it.kidx   = 14'($urandom);
        it.mapped = 1'($urandom);
        it.rune   = 16'($urandom);
        feed(it, EXP_MODEL, no_res);
    endtask

    task automatic feed_load();
        t_jis_item it;
        it.load   = 1'b1;
        it.octet  = 8'($urandom);
        it.eoi    = 1'($urandom);
        it.kidx   = 14'($urandom);
        it.mapped = 1'($urandom);
        it.rune   = 16'($urandom);
        feed(it, EXP_MODEL, no_res);
    endtask

    task automatic tbl_row(t_exp_kind kind, bit load, logic [7:0] oct, bit eoi,
                           logic [13:0] kidx, bit mapped, logic [15:0] rune,
                           logic [15:0] xr, bit xu, logic [31:0] xe);
        t_dir_row row;
        row.kind          = kind;
        row.stim.load     = load;
        row.stim.octet    = oct;
        row.stim.eoi      = eoi;
        row.stim.kidx     = kidx;
        row.stim.mapped   = mapped;
        row.stim.rune     = rune;
        row.want.rune     = xr;
        row.want.unmapped = xu;
        row.want.err      = xe;
        row.want.last     = 1'b1;
        dir_rows.push_back(row);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_runes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(bit drop, logic [15:0] bad);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= i2jd_pkg::CFG_DROP_UNMAPPED;
        i_cfg_data  <= {15'($urandom), drop};
        @(posedge i_clk);
        drop_cfg = drop;
        i_cfg_index <= i2jd_pkg::CFG_BAD_RUNE;
        i_cfg_data  <= bad;
        @(posedge i_clk);
        bad_cfg = bad;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int quota);
        int start;
        int sel;
        int s;
        logic [7:0] hi;
        logic [7:0] b;
        start = fed_count;
        while (fed_count - start < quota) begin
            if ($urandom_range(0, 39) == 0)
                tx_burst = !tx_burst;
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                repeat ($urandom_range(1, 4)) begin
                    hi = $urandom_range(0, 1) ? i2jd_pkg::HIGH_BIT : 8'h00;
                    s  = $urandom_range(0, 3);
                    if (s == 0) begin
                        feed_byte($urandom_range(0, 255));
                        feed_byte($urandom_range(0, 255));
                    end else if (s == 1) begin
                        feed_byte(hi | $urandom_range(8'h21, 8'h28));
                        feed_byte(hi | $urandom_range(8'h21, 8'h28));
                    end else begin
                        feed_byte(hi | $urandom_range(8'h21, 8'h7E));
                        feed_byte(hi | $urandom_range(8'h21, 8'h7E));
                    end
                end
            end else if (sel < 40) begin
                repeat ($urandom_range(1, 5)) begin
                    b = 8'($urandom_range(0, 127));
                    if (b == i2jd_pkg::CH_ESC || $urandom_range(0, 4) == 0)
                        b = $urandom_range(0, 1) ? i2jd_pkg::CH_BSLASH : i2jd_pkg::CH_TILDE;
                    feed_byte(b);
                end
            end else if (sel < 55) begin
                feed_byte(i2jd_pkg::CH_ESC);
                if ($urandom_range(0, 1)) begin
                    feed_byte(i2jd_pkg::CH_DOLLAR);
                    feed_byte($urandom_range(0, 1) ? i2jd_pkg::CH_AT : i2jd_pkg::CH_B);
                end else begin
                    feed_byte(i2jd_pkg::CH_PAREN);
                    s = $urandom_range(0, 2);
                    feed_byte(s == 0 ? i2jd_pkg::CH_J
                                     : (s == 1 ? i2jd_pkg::CH_H : i2jd_pkg::CH_B));
                end
            end else if (sel < 65) begin
                feed_byte(i2jd_pkg::CH_ESC);
                s = $urandom_range(0, 2);
                if (s == 1)
                    feed_byte(i2jd_pkg::CH_DOLLAR);
                else if (s == 2)
                    feed_byte(i2jd_pkg::CH_PAREN);
                feed_byte($urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 255));
            end else if (sel < 73) begin
                feed_byte(-1);
            end else if (sel < 83) begin
                feed_load();
            end else begin
                feed_byte($urandom_range(0, 255));
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        //      expect     ld oct                  eoi idx        map rune      want   unm err
        tbl_row(EXP_ONE,   0, 8'h00,               0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_ONE,   0, i2jd_pkg::CH_BSLASH, 0,  14'd0,     0,  16'h0000, 16'h005C, 0, 0);
        tbl_row(EXP_NONE,  1, 8'h00,               0,  14'd101,   1,  16'h3000, 16'h0000, 0, 0);
        tbl_row(EXP_NONE,  1, 8'hFF,               1,  14'd16383, 1,  16'hFFFF, 16'h0000, 0, 0);
        tbl_row(EXP_NONE,  1, 8'h00,               0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_NONE,  1, 8'h00,               0,  14'd3301,  1,  16'h1234, 16'h0000, 0, 0);
        // high byte alone, completed at end of input
        tbl_row(EXP_NONE,  0, 8'hA1,               0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_ONE,   0, 8'h00,               1,  14'd0,     0,  16'h0000, 16'h3000, 0, 0);
        tbl_row(EXP_NONE,  0, i2jd_pkg::CH_ESC,    0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_NONE,  0, i2jd_pkg::CH_DOLLAR, 0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_NONE,  0, i2jd_pkg::CH_B,      0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        // unmapped entry, then negative index
        tbl_row(EXP_NONE,  0, 8'h20,               0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_ONE,   0, 8'h20,               0,  14'd0,     0,  16'h0000, 16'hFFFD, 1, 1);
        tbl_row(EXP_NONE,  0, 8'h80,               0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_ONE,   0, 8'h80,               0,  14'd0,     0,  16'h0000, 16'hFFFD, 1, 2);
        // high bits differ: raw first byte, second one restarts a pair
        tbl_row(EXP_NONE,  0, 8'hFF,               0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_ONE,   0, 8'h41,               0,  14'd0,     0,  16'h0000, 16'h00FF, 0, 2);
        tbl_row(EXP_ONE,   0, 8'h00,               1,  14'd0,     0,  16'h0000, 16'h1234, 0, 2);
        tbl_row(EXP_NONE,  0, i2jd_pkg::CH_ESC,    0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_NONE,  0, i2jd_pkg::CH_PAREN,  0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_NONE,  0, i2jd_pkg::CH_J,      0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_ONE,   0, i2jd_pkg::CH_BSLASH, 0,  14'd0,     0,  16'h0000, 16'h00A5, 0, 2);
        tbl_row(EXP_ONE,   0, i2jd_pkg::CH_TILDE,  0,  14'd0,     0,  16'h0000, 16'h00AF, 0, 2);
        // broken escapes replay their bytes
        tbl_row(EXP_MODEL, 0, i2jd_pkg::CH_ESC,    0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_MODEL, 0, 8'h58,               0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_MODEL, 0, i2jd_pkg::CH_ESC,    0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_MODEL, 0, i2jd_pkg::CH_PAREN,  0,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);
        tbl_row(EXP_MODEL, 0, 8'h00,               1,  14'd0,     0,  16'h0000, 16'h0000, 0, 0);

        foreach (dir_rows[k])
            feed(dir_rows[k].stim, dir_rows[k].kind, dir_rows[k].want);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_config(1'b1, 16'h0000);
                1: set_config(1'b0, 16'hFFFF);
                2: set_config(1'b0, 16'($urandom));
                3: set_config(1'b1, 16'($urandom));
                default: set_config(1'b0, i2jd_pkg::BAD_RUNE_RST);
            endcase
            random_phase(RANDOM_ITEMS / 5);
        end

        settle();
        if (fail_count == 0)
            $display("PASS iso2022jp_decoder_top");
        else
            $display("FAIL iso2022jp_decoder_top");
        $finish;
    end

    always @(posedge i_clk) begin : rune_check
        t_rune_res want;
        int r;
        rx_cycles++;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_runes.size() == 0) begin
                $error("unexpected rune transaction: rune %h", o_m_axis_tdata[15:0]);
                fail_count++;
            end else begin
                want = expected_runes.pop_front();
                if (o_m_axis_tdata[15:0] !== want.rune) begin
                    $error("rune: expected %h, got %h", want.rune, o_m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[16] !== want.unmapped) begin
                    $error("unmapped: expected %b, got %b", want.unmapped, o_m_axis_tdata[16]);
                    fail_count++;
                end
                if (o_m_axis_tdata[48:17] !== want.err) begin
                    $error("error_total: expected %0d, got %0d", want.err,
                           o_m_axis_tdata[48:17]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
        if (rx_cycles % 300 == 0)
            rx_free = ($urandom_range(0, 3) == 0);
        if (rx_stall > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall--;
        end else if (rx_free) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                i_m_axis_tready <= 1'b1;
            end else if (r < 96) begin
                i_m_axis_tready <= 1'b0;
                rx_stall = $urandom_range(0, 2);
            end else begin
                i_m_axis_tready <= 1'b0;
                rx_stall = $urandom_range(8, 30);
            end
        end
    end

    initial begin : watchdog
        wait (rx_cycles >= CYCLE_LIMIT);
        $display("FAIL iso2022jp_decoder_top");
        $finish;
    end

endmodule
